// ===== hw/rtl/linear_probe_hash_table_top_defines.svh =====
// Assertion macros shared by the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset.
`define LPHT_ASSERT_NXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lpht_pkg.sv =====
// Shared types and codes of the linear probe hash table.
package lpht_pkg;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 11;
    localparam int IN_DW    = KEY_W + VAL_W;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd512;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_KEY  = 2'd3;

    typedef enum logic [2:0] {
        K_INSERT,
        K_LOOKUP,
        K_DELETE,
        K_ZERO,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP,
        S_RESOLVE,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/lpht_front.sv =====
// Front end: accepts input items and classifies them into operations.
module lpht_front (
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [lpht_pkg::IN_DW-1:0]    i_s_axis_tdata,
    input  logic [lpht_pkg::MODE_W-1:0]   i_s_axis_tuser,
    input  logic                          i_hold,
    input  logic                          i_q_full,
    output logic                          o_push,
    output lpht_pkg::t_op                 o_op
);
    import lpht_pkg::*;

    logic [KEY_W-1:0] key;

    assign key             = i_s_axis_tdata[KEY_W-1:0];
    assign o_s_axis_tready = !i_q_full && !i_hold;
    assign o_push          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        o_op.key   = key;
        o_op.value = i_s_axis_tdata[IN_DW-1:KEY_W];
        // An unused mode wins over a zero key.
        priority if (i_s_axis_tuser != MODE_INSERT && i_s_axis_tuser != MODE_LOOKUP
                     && i_s_axis_tuser != MODE_DELETE) begin
            o_op.kind = K_BAD;
        end else if (key == '0) begin
            o_op.kind = K_ZERO;
        end else if (i_s_axis_tuser == MODE_INSERT) begin
            o_op.kind = K_INSERT;
        end else if (i_s_axis_tuser == MODE_LOOKUP) begin
            o_op.kind = K_LOOKUP;
        end else begin
            o_op.kind = K_DELETE;
        end
    end

endmodule

// ===== hw/rtl/lpht_queue.sv =====
// Two-entry queue of classified operations between front and back.
module lpht_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpht_pkg::t_op  i_op,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output lpht_pkg::t_op  o_op
);
    import lpht_pkg::*;

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule

// ===== hw/rtl/lpht_back.sv =====
// Back end: probe engine over the slot memories and the result register.
module lpht_back #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  lpht_pkg::t_op                 i_q_op,
    output logic                          o_q_pop,
    input  logic [lpht_pkg::CNT_W-1:0]    i_max_entries,
    output logic                          o_clearing,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lpht_pkg::VAL_W-1:0]    o_m_axis_tdata,
    output logic [lpht_pkg::STAT_W-1:0]   o_m_axis_tuser
);
    import lpht_pkg::*;

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam bit IS_POW2 = ((1 << AW) == TABLE_SIZE);
    localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);
    localparam int RS = AW + 8;
    localparam longint RECIP_L = (longint'(1) << RS) / TABLE_SIZE;
    localparam logic [9:0]    RECIP = 10'(RECIP_L);
    localparam logic [AW+9:0] TSW   = (AW+10)'(TABLE_SIZE);

    // Slot memory word: tombstone flag above the key.
    logic [KEY_W:0]   key_mem [TABLE_SIZE];
    logic [VAL_W-1:0] val_mem [TABLE_SIZE];

    t_state            r_state, n_state;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_n;
    logic [CNT_W-1:0]  r_live;
    logic              r_ovalid;
    t_op               r_op;
    logic              r_hit;
    logic              r_ff_valid;
    logic [AW-1:0]     r_ff;
    logic [AW-1:0]     r_rem;
    logic [2:0]        r_bit;
    logic [KEY_W:0]    r_krd;
    logic [VAL_W-1:0]  r_vrd;
    logic [VAL_W-1:0]  r_hval;
    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_vout;
    logic [STAT_W-1:0] r_ostatus;
    logic [VAL_W-1:0]  r_ovalue;

    logic              key_we, val_we;
    logic [AW-1:0]     key_wa, val_wa;
    logic [KEY_W:0]    key_wd;
    logic [STAT_W-1:0] res_status;
    logic              out_load;
    logic              slot_empty, slot_tomb, slot_match, probe_last;
    logic              no_room;
    logic [AW+7:0]     rem_x;
    logic [AW+17:0]    rem_prod;
    logic [9:0]        rem_q;
    logic [AW+9:0]     rem_r1;
    logic [AW-1:0]     rem_next;
    logic [AW-1:0]     idx_inc;

    assign slot_tomb  = r_krd[KEY_W];
    assign slot_empty = !slot_tomb && (r_krd[KEY_W-1:0] == '0);
    assign slot_match = !slot_tomb && (r_krd[KEY_W-1:0] == r_op.key);
    assign probe_last = (r_n == LAST);
    assign idx_inc    = (r_idx == LAST) ? '0 : r_idx + AW'(1);
    assign no_room    = (r_live >= i_max_entries) || !r_ff_valid;

    // Home slot remainder, one key byte per cycle from the top. The quotient
    // estimate from the reciprocal multiply is at most one short, so a single
    // compare and subtract finishes each step.
    assign rem_x    = {r_rem, r_op.key[{~r_bit, 3'b000} +: 8]};
    assign rem_prod = rem_x * RECIP;
    assign rem_q    = rem_prod[AW+17:RS];
    assign rem_r1   = (AW+10)'(rem_x) - (AW+10)'(rem_q) * TSW;
    assign rem_next = (rem_r1 >= TSW) ? AW'(rem_r1 - TSW) : AW'(rem_r1);

    assign o_clearing      = (r_state == S_CLEAR);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_ovalue;
    assign o_m_axis_tuser  = r_ostatus;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_op.kind == K_ZERO || i_q_op.kind == K_BAD) begin
                        n_state = S_OUT;
                    end else if (IS_POW2) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (r_bit == 3'd7) n_state = S_READ;
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (slot_empty || slot_match || probe_last) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_RESOLVE: n_state = S_OUT;
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        key_we     = 1'b0;
        key_wa     = r_idx;
        key_wd     = '0;
        val_we     = 1'b0;
        val_wa     = r_idx;
        res_status = ST_NOT_FOUND;
        o_q_pop    = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_CLEAR: key_we = 1'b1;
            S_IDLE:  o_q_pop = i_q_valid;
            S_RESOLVE: begin
                unique case (r_op.kind)
                    K_INSERT: begin
                        if (r_hit) begin
                            val_we     = 1'b1;
                            res_status = ST_OK;
                        end else if (no_room) begin
                            res_status = ST_FULL;
                        end else begin
                            key_we     = 1'b1;
                            key_wa     = r_ff;
                            key_wd     = {1'b0, r_op.key};
                            val_we     = 1'b1;
                            val_wa     = r_ff;
                            res_status = ST_OK;
                        end
                    end
                    K_LOOKUP: res_status = r_hit ? ST_OK : ST_NOT_FOUND;
                    K_DELETE: begin
                        if (r_hit) begin
                            key_we     = 1'b1;
                            key_wd     = {1'b1, r_op.key};
                            res_status = ST_OK;
                        end
                    end
                    default: res_status = ST_NOT_FOUND;
                endcase
            end
            S_OUT: out_load = !r_ovalid || i_m_axis_tready;
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_idx <= idx_inc;
                S_IDLE: begin
                    if (i_q_valid && IS_POW2) r_idx <= i_q_op.key[AW-1:0];
                end
                S_HASH: begin
                    if (r_bit == 3'd7) r_idx <= rem_next;
                end
                S_CMP: begin
                    if (!slot_empty && !slot_match && !probe_last) r_idx <= idx_inc;
                end
                S_RESOLVE: begin
                    if (r_op.kind == K_INSERT && !r_hit && !no_room) begin
                        r_live <= r_live + CNT_W'(1);
                    end else if (r_op.kind == K_DELETE && r_hit && r_live != '0) begin
                        r_live <= r_live - CNT_W'(1);
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op       <= i_q_op;
                r_n        <= '0;
                r_hit      <= 1'b0;
                r_ff_valid <= 1'b0;
                r_rem      <= '0;
                r_bit      <= '0;
                r_vout     <= '0;
                r_status   <= (i_q_op.kind == K_ZERO) ? ST_ZERO_KEY : ST_NOT_FOUND;
            end
            S_HASH: begin
                r_rem <= rem_next;
                r_bit <= r_bit + 3'd1;
            end
            S_CMP: begin
                r_n <= r_n + AW'(1);
                if ((slot_empty || slot_tomb) && !r_ff_valid) begin
                    r_ff_valid <= 1'b1;
                    r_ff       <= r_idx;
                end
                if (slot_match) begin
                    r_hit  <= 1'b1;
                    r_hval <= r_vrd;
                end
            end
            S_RESOLVE: begin
                r_status <= res_status;
                r_vout   <= (r_op.kind == K_LOOKUP && r_hit) ? r_hval : '0;
            end
            S_OUT: begin
                if (out_load) begin
                    r_ostatus <= r_status;
                    r_ovalue  <= r_vout;
                end
            end
            default: r_rem <= r_rem;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[key_wa] <= key_wd;
        r_krd <= key_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) val_mem[val_wa] <= r_op.value;
        r_vrd <= val_mem[r_idx];
    end

endmodule

// ===== hw/rtl/linear_probe_hash_table_top.sv =====
// An accepted item passes through the two-entry queue to the probe engine, which first
// reduces the key to its home slot when TABLE_SIZE is not a power of two, then
// does one memory read and compare per probe, resolves, and loads the output register;
// a zero key or an unused mode skips probing. The probe engine holds one item at a
// time; a two-entry queue and the output register let the front and the result side
// stall independently. Reset is synchronous, active low: afterwards a clearing pass
// over all TABLE_SIZE slots empties the slot memory; no item is accepted until it ends.
module linear_probe_hash_table_top #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata, from bit 0 up: key [63:0], value [95:64].
    input  logic [lpht_pkg::IN_DW-1:0]    i_s_axis_tdata,
    // tuser: mode [1:0].
    input  logic [lpht_pkg::MODE_W-1:0]   i_s_axis_tuser,
    // Result items.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: value_out [31:0].
    output logic [lpht_pkg::VAL_W-1:0]    o_m_axis_tdata,
    // tuser: status [1:0].
    output logic [lpht_pkg::STAT_W-1:0]   o_m_axis_tuser,
    // The max_entries register.
    input  logic                          i_cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0]    i_cfg_wdata
);
    import lpht_pkg::*;

    logic [CNT_W-1:0] r_max;
    logic             push, q_full, q_valid, q_pop, clearing;
    t_op              f_op, q_op;

    // The live entry limit; the back end compares it against its live count
    // only when an insert of a new key resolves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_ENTRIES_RST;
        end else begin
            if (i_cfg_we) r_max <= i_cfg_wdata;
        end
    end

    // The front end classifies each item: unused modes and zero keys are
    // settled without probing, but they still go through the queue so that
    // results keep input order.
    lpht_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_hold          (clearing),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_op            (f_op)
    );

    lpht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_op    (q_op)
    );

    // The back end walks the probe run one slot per read, remembers the first
    // reusable slot, and commits the insert, update or tombstone at the end.
    lpht_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_op          (q_op),
        .o_q_pop         (q_pop),
        .i_max_entries   (r_max),
        .o_clearing      (clearing),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== hw/rtl/lpht_checker.sv =====
// Port-level checker for the hash table, bound to the top level.
`include "linear_probe_hash_table_top_defines.svh"

module lpht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [lpht_pkg::VAL_W-1:0]    o_m_axis_tdata,
    input logic [lpht_pkg::STAT_W-1:0]   o_m_axis_tuser
);
    import lpht_pkg::*;

    `LPHT_ASSERT_IMP(a_value_only_on_ok, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK, o_m_axis_tdata == '0,
        "result value nonzero without success")
    `LPHT_ASSERT_NXT(a_clear_after_reset, i_clk, !i_rst_n, !o_s_axis_tready,
        "input ready during clearing pass")
    `LPHT_ASSERT_IMP(a_out_hold, i_clk, i_rst_n,
        $past(i_rst_n && o_m_axis_tvalid && !i_m_axis_tready),
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "stalled result changed")
    `LPHT_ASSERT_IMP(a_out_drop, i_clk, i_rst_n,
        $fell(o_m_axis_tvalid) && $past(i_rst_n), $past(i_m_axis_tready),
        "result withdrawn without handshake")

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);
